>>> sv/spd_pkg.sv
// Package for the serial packet deframer: frame phase and byte kind codes,
// configuration register indexes, reset values and the per-byte result record.
// No dependencies.
package spd_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 16;
  localparam int unsigned LEN_W             = 16;
  localparam int unsigned TOTAL_W           = 16;

  localparam logic [7:0]       SYNC_BYTE       = 8'hff;
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST  = 16'd1024;

  // Configuration register indexes
  localparam logic CFG_PACKET_ENABLE = 1'b0;
  localparam logic CFG_MAX_LENGTH    = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_LENHI = 3'd2,
    PH_SUM   = 3'd3,
    PH_DATA  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0]         byte_value;
    kind_e              byte_kind;
    logic [LEN_W-1:0]   payload_index;
    logic               frame_end;
    logic               frame_good;
    logic [LEN_W-1:0]   frame_length;
    logic               frame_rejected;
    logic [TOTAL_W-1:0] good_total;
    logic [TOTAL_W-1:0] bad_total;
  } result_t;

endpackage

>>> sv/spd_deframe_core.sv
// Frame tracking core: phase, length, checksum and counter state, and the
// combinational result for the byte held in the input register.
// Depends on spd_pkg.
module spd_deframe_core import spd_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             packet_enable_i,
  input  logic [LEN_W-1:0] max_length_i,
  input  logic [7:0]       rx_byte_i,
  output result_t          result_o
);

  phase_e                   phase_q, phase_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [7:0]               exp_q, exp_d;
  logic [7:0]               sum_q, sum_d;
  logic [LEN_W-1:0]         cnt_q, cnt_d;
  logic [COUNTER_WIDTH-1:0] good_q, good_d;
  logic [COUNTER_WIDTH-1:0] bad_q, bad_d;

  logic             in_frame;
  logic [LEN_W-1:0] len_new;
  logic [LEN_W:0]   cnt_next;
  logic [7:0]       sum_new;
  kind_e            kind;
  logic [LEN_W-1:0] index;
  logic             end_flag, good_flag, rej_flag;

  assign in_frame = packet_enable_i && ((phase_q != PH_IDLE) || (rx_byte_i == SYNC_BYTE));
  assign len_new  = {len_q[LEN_W-1:8], rx_byte_i};
  assign cnt_next = {1'b0, cnt_q} + (LEN_W+1)'(1);
  assign sum_new  = sum_q + rx_byte_i;

  // Advance the frame state for the current byte
  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    exp_d     = exp_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    good_d    = good_q;
    bad_d     = bad_q;
    kind      = KIND_PLAIN;
    index     = '0;
    end_flag  = 1'b0;
    good_flag = 1'b0;
    rej_flag  = 1'b0;
    if (in_frame) begin
      kind = KIND_HEADER;
      case (phase_q)
        PH_SYNC: begin
          len_d   = {rx_byte_i, 8'h00};
          phase_d = PH_LENHI;
        end
        PH_LENHI: begin
          len_d = len_new;
          if (len_new <= max_length_i) begin
            phase_d = PH_SUM;
          end else begin
            rej_flag = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
        PH_SUM: begin
          exp_d   = rx_byte_i;
          sum_d   = '0;
          cnt_d   = '0;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          kind  = KIND_PAYLOAD;
          index = cnt_q;
          sum_d = sum_new;
          cnt_d = cnt_next[LEN_W-1:0];
          if (cnt_next >= {1'b0, len_q}) begin
            end_flag = 1'b1;
            phase_d  = PH_IDLE;
            if (sum_new == exp_q) begin
              good_flag = 1'b1;
              good_d    = good_q + COUNTER_WIDTH'(1);
            end else begin
              bad_d = bad_q + COUNTER_WIDTH'(1);
            end
          end
        end
        default: begin
          // idle: the sync byte opens a frame; an unused code also goes to the sync phase
          phase_d = PH_SYNC;
        end
      endcase
    end
  end

  // Build the result record
  always_comb begin
    result_o.byte_value     = rx_byte_i;
    result_o.byte_kind      = kind;
    result_o.payload_index  = index;
    result_o.frame_end      = end_flag;
    result_o.frame_good     = good_flag;
    result_o.frame_length   = in_frame ? len_d : '0;
    result_o.frame_rejected = rej_flag;
    result_o.good_total     = TOTAL_W'(good_d);
    result_o.bad_total      = TOTAL_W'(bad_d);
  end

  // Commit state when the byte moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= '0;
      exp_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      good_q  <= '0;
      bad_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      exp_q   <= exp_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      good_q  <= good_d;
      bad_q   <= bad_d;
    end
  end

endmodule

>>> sv/serial_packet_deframer.sv
// Serial packet deframer: takes one received byte per request and returns one
// result per byte. Frames are sync 0xff, length high, length low, 8-bit sum,
// then payload; with packet_enable low every byte passes as plain data. The
// block takes a byte every clock cycle while the result side is not stalled
// and returns results in order; a byte is held in the input register, where
// the frame state is applied, and its result then moves to the result register
// when that register is free or being drained, which commits the frame state.
// Depends on spd_pkg and spd_deframe_core.
module serial_packet_deframer import spd_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [LEN_W-1:0]   cfg_data_i,
  // received bytes
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  // results
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [7:0]         byte_value_o,
  output logic [1:0]         byte_kind_o,
  output logic [LEN_W-1:0]   payload_index_o,
  output logic               frame_end_o,
  output logic               frame_good_o,
  output logic [LEN_W-1:0]   frame_length_o,
  output logic               frame_rejected_o,
  output logic [TOTAL_W-1:0] good_total_o,
  output logic [TOTAL_W-1:0] bad_total_o
);

  logic             pkt_en_q;
  logic [LEN_W-1:0] max_len_q;
  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          core_res;
  logic             step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_en_q  <= 1'b0;
      max_len_q <= MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PACKET_ENABLE: pkt_en_q  <= cfg_data_i[0];
        CFG_MAX_LENGTH:    max_len_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // Move a byte to the result stage when that stage is free or being drained
  assign step       = in_valid_q && (!out_valid_q || res_ready_i);
  assign rx_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_ready_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  spd_deframe_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .packet_enable_i(pkt_en_q),
    .max_length_i   (max_len_q),
    .rx_byte_i      (in_byte_q),
    .result_o       (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= core_res;
    end
  end

  assign res_valid_o      = out_valid_q;
  assign byte_value_o     = out_q.byte_value;
  assign byte_kind_o      = out_q.byte_kind;
  assign payload_index_o  = out_q.payload_index;
  assign frame_end_o      = out_q.frame_end;
  assign frame_good_o     = out_q.frame_good;
  assign frame_length_o   = out_q.frame_length;
  assign frame_rejected_o = out_q.frame_rejected;
  assign good_total_o     = out_q.good_total;
  assign bad_total_o      = out_q.bad_total;

endmodule

>>> tb/sv/serial_packet_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_packet_deframer: drives received bytes,
// predicts each per-byte result in step and compares it with the block's output.
// Depends on spd_pkg and the serial_packet_deframer RTL.
module serial_packet_deframer_tb import spd_pkg::*; ();

  typedef enum int {
    TX_LIGHT_RX_HEAVY,
    TX_HEAVY_RX_LIGHT,
    NO_GAPS
  } gap_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [LEN_W-1:0]   cfg_data_i;
  logic               rx_valid_i;
  logic               rx_ready_o;
  logic [7:0]         rx_byte_i;
  logic               res_valid_o;
  logic               res_ready_i;
  logic [7:0]         byte_value_o;
  logic [1:0]         byte_kind_o;
  logic [LEN_W-1:0]   payload_index_o;
  logic               frame_end_o;
  logic               frame_good_o;
  logic [LEN_W-1:0]   frame_length_o;
  logic               frame_rejected_o;
  logic [TOTAL_W-1:0] good_total_o;
  logic [TOTAL_W-1:0] bad_total_o;

  serial_packet_deframer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .byte_value_o     (byte_value_o),
    .byte_kind_o      (byte_kind_o),
    .payload_index_o  (payload_index_o),
    .frame_end_o      (frame_end_o),
    .frame_good_o     (frame_good_o),
    .frame_length_o   (frame_length_o),
    .frame_rejected_o (frame_rejected_o),
    .good_total_o     (good_total_o),
    .bad_total_o      (bad_total_o)
  );

  // Bytes waiting to be sent and deframed results waiting to come out
  logic [7:0]  rx_backlog[$];
  result_t     deframed_q[$];
  int unsigned bytes_queued;
  int unsigned fail_count;
  gap_mode_e   gap_mode;
  result_t     want;

  // Shadow copy of the configuration registers
  logic             pkt_en;
  logic [LEN_W-1:0] len_limit;

  // Shadow copy of the frame state
  phase_e             st_phase;
  logic [LEN_W-1:0]   st_length;
  logic [7:0]         st_sum_hdr;
  logic [7:0]         st_sum_run;
  logic [LEN_W-1:0]   st_count;
  logic [TOTAL_W-1:0] st_good;
  logic [TOTAL_W-1:0] st_bad;

  // Clock
  always #10 clk_i = ~clk_i;

  // Advance the shadow frame state by one byte and queue the result it gives
  function automatic void deframe_byte(input logic [7:0] b);
    result_t     r;
    logic [16:0] next;
    logic        in_frame;
    r = '0;
    r.byte_value = b;
    r.byte_kind = KIND_PLAIN;
    in_frame = pkt_en && (st_phase != PH_IDLE || b == SYNC_BYTE);
    if (in_frame) begin
      r.byte_kind = KIND_HEADER;
      case (st_phase)
        PH_IDLE: st_phase = PH_SYNC;
        PH_SYNC: begin
          st_length = {b, 8'h00};
          st_phase = PH_LENHI;
        end
        PH_LENHI: begin
          st_length = {st_length[15:8], b};
          if (st_length <= len_limit) begin
            st_phase = PH_SUM;
          end else begin
            r.frame_rejected = 1'b1;
            st_phase = PH_IDLE;
          end
        end
        PH_SUM: begin
          st_sum_hdr = b;
          st_sum_run = 8'h00;
          st_count = '0;
          st_phase = PH_DATA;
        end
        default: begin
          next = {1'b0, st_count} + 17'd1;
          r.byte_kind = KIND_PAYLOAD;
          r.payload_index = st_count;
          st_sum_run = st_sum_run + b;
          st_count = next[15:0];
          // a zero length frame still ends on its first payload byte
          if (next >= {1'b0, st_length}) begin
            r.frame_end = 1'b1;
            if (st_sum_run == st_sum_hdr) begin
              r.frame_good = 1'b1;
              st_good = st_good + 16'd1;
            end else begin
              st_bad = st_bad + 16'd1;
            end
            st_phase = PH_IDLE;
          end
        end
      endcase
      r.frame_length = st_length;
    end
    r.good_total = st_good;
    r.bad_total = st_bad;
    deframed_q.push_back(r);
  endfunction

  function automatic bit sender_idles();
    case (gap_mode)
      TX_LIGHT_RX_HEAVY: return $urandom_range(0, 99) < 27;
      TX_HEAVY_RX_LIGHT: return $urandom_range(0, 99) < 87;
      default:           return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (gap_mode)
      TX_LIGHT_RX_HEAVY: return $urandom_range(0, 99) < 87;
      TX_HEAVY_RX_LIGHT: return $urandom_range(0, 99) < 27;
      default:           return 1'b0;
    endcase
  endfunction

  // Driver: predict on each accepted request, then present the next byte
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) begin
        deframe_byte(rx_byte_i);
      end
      if (!rx_valid_i || rx_ready_o) begin
        if (rx_backlog.size() > 0 && !sender_idles()) begin
          rx_byte_i  <= rx_backlog.pop_front();
          rx_valid_i <= 1'b1;
        end else begin
          rx_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (deframed_q.size() == 0) begin
          $error("result with no byte outstanding: value 0x%0h", byte_value_o);
          fail_count++;
        end else begin
          want = deframed_q.pop_front();
          check_field("byte_value", 16'(want.byte_value), 16'(byte_value_o));
          check_field("byte_kind", 16'(want.byte_kind), 16'(byte_kind_o));
          check_field("payload_index", want.payload_index, payload_index_o);
          check_field("frame_end", 16'(want.frame_end), 16'(frame_end_o));
          check_field("frame_good", 16'(want.frame_good), 16'(frame_good_o));
          check_field("frame_length", want.frame_length, frame_length_o);
          check_field("frame_rejected", 16'(want.frame_rejected),
                      16'(frame_rejected_o));
          check_field("good_total", want.good_total, good_total_o);
          check_field("bad_total", want.bad_total, bad_total_o);
        end
      end
      res_ready_i <= !receiver_stalls();
    end
  end

  function automatic void push_byte(input logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endfunction

  // Write one register while nothing is in flight
  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PACKET_ENABLE) begin
      pkt_en = data[0];
    end else begin
      len_limit = data;
    end
  endtask

  // Hold until every byte is sent and every result is back, then let the pipe settle
  task automatic drain();
    while (rx_backlog.size() > 0 || rx_valid_i || deframed_q.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Queue a frame, header only if oversize; optionally a bad sum or a cut-short body
  task automatic queue_frame(input int unsigned len, input bit sum_ok, input bit cut);
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [7:0]  bad_sum;
    int unsigned n;
    int unsigned keep;
    n = (len == 0) ? 1 : len;
    sum = 8'h00;
    for (int i = 0; i < n; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
      sum = sum + body[i];
    end
    bad_sum = sum + 8'($urandom_range(1, 255));
    push_byte(SYNC_BYTE);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
    if (len > len_limit) return;
    push_byte(sum_ok ? sum : bad_sum);
    keep = cut ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < keep; i++) begin
      push_byte(body[i]);
    end
  endtask

  // Mostly well-formed frames, with oversize headers, cut frames and line noise
  task automatic queue_random(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      pick = $urandom_range(0, 9);
      if (len_limit != 16'hffff && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(len_limit + 1, 16'hffff);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
        if (len > len_limit) len = 32'(len_limit);
      end
      if (pick < 7) begin
        queue_frame(len, $urandom_range(0, 4) != 0, 1'b0);
      end else if (pick == 7) begin
        queue_frame(len, 1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Stimulus
  initial begin
    bit        seg_en[6];
    int        seg_max[6];
    gap_mode_e seg_gap[6];
    seg_en  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    seg_max = '{0, 65535, 20, 7, 1, 300};
    seg_gap = '{TX_LIGHT_RX_HEAVY, TX_LIGHT_RX_HEAVY, TX_HEAVY_RX_LIGHT,
                TX_HEAVY_RX_LIGHT, NO_GAPS, NO_GAPS};
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_PACKET_ENABLE;
    cfg_data_i  = '0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    res_ready_i = 1'b0;
    bytes_queued = 0;
    fail_count   = 0;
    gap_mode     = TX_LIGHT_RX_HEAVY;
    pkt_en       = 1'b0;
    len_limit    = MAX_LENGTH_RST;
    st_phase     = PH_IDLE;
    st_length    = '0;
    st_sum_hdr   = 8'h00;
    st_sum_run   = 8'h00;
    st_count     = '0;
    st_good      = '0;
    st_bad       = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // detection off after reset: everything is plain data, sync byte too
    push_byte(8'h00);
    push_byte(SYNC_BYTE);
    push_byte(8'h5a);
    drain();
    write_reg(CFG_PACKET_ENABLE, 16'd1);
    write_reg(CFG_MAX_LENGTH, 16'd4);
    // good two-byte frame with a sync byte inside the payload
    push_byte(SYNC_BYTE); push_byte(8'h00); push_byte(8'h02); push_byte(8'h00);
    push_byte(SYNC_BYTE); push_byte(8'h01);
    // zero length frame still takes one payload byte
    push_byte(SYNC_BYTE); push_byte(8'h00); push_byte(8'h00); push_byte(8'h07);
    push_byte(8'h07);
    // largest length, rejected
    push_byte(SYNC_BYTE); push_byte(8'hff); push_byte(8'hff);
    // start a frame, then turn detection off in the middle of it
    push_byte(SYNC_BYTE); push_byte(8'h00); push_byte(8'h03);
    drain();
    write_reg(CFG_PACKET_ENABLE, 16'd0);
    push_byte(8'h3c);
    push_byte(SYNC_BYTE);
    drain();
    // resume the frame with a wrong sum
    write_reg(CFG_PACKET_ENABLE, 16'd1);
    push_byte(8'h10); push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
    drain();

    // random segments over several settings and gap patterns
    for (int s = 0; s < 6; s++) begin
      gap_mode = seg_gap[s];
      write_reg(CFG_PACKET_ENABLE, {15'd0, seg_en[s]});
      write_reg(CFG_MAX_LENGTH, seg_max[s][15:0]);
      queue_random(155);
      drain();
    end

    if (fail_count == 0) begin
      $display("[serial_packet_deframer] OK");
    end else begin
      $display("[serial_packet_deframer] ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("[serial_packet_deframer] ERROR");
    $finish;
  end

endmodule

>>> sim.f
sv/spd_pkg.sv
sv/spd_deframe_core.sv
sv/serial_packet_deframer.sv
tb/sv/serial_packet_deframer_tb.sv
